FILE: rtl/sfd_pkg.sv
// sfd_pkg: shared types, constants and the crystal lookup for the system clock decode
// used by system_clock_frequency_decode and its port checker; no dependencies

package sfd_pkg;

  // result and divider widths
  localparam int FREQ_W          = 29;  // up to 400 MHz
  localparam int DIV_W           = 8;   // divisor 1 .. 128
  localparam int REM_W           = 7;   // remainder below the divisor
  localparam int STEPS_PER_STG   = 4;   // quotient bits resolved per divider stage
  localparam int NUM_DIV_STG     = (FREQ_W + STEPS_PER_STG - 1) / STEPS_PER_STG;
  localparam int CRYSTAL_ENTRIES = 27;

  // fixed frequencies in hertz
  localparam logic [FREQ_W-1:0] HZ_PLL_400 = 29'd400000000;
  localparam logic [FREQ_W-1:0] HZ_PLL_200 = 29'd200000000;
  localparam logic [FREQ_W-1:0] HZ_PIOSC   = 29'd16000000;
  localparam logic [FREQ_W-1:0] HZ_PIOSC4  = 29'd4000000;
  localparam logic [FREQ_W-1:0] HZ_LFIOSC  = 29'd33000;
  localparam logic [FREQ_W-1:0] HZ_32K     = 29'd32768;

  // oscillator source codes
  localparam logic [2:0] SRC_MOSC   = 3'd0;
  localparam logic [2:0] SRC_PIOSC  = 3'd1;
  localparam logic [2:0] SRC_PIOSC4 = 3'd2;
  localparam logic [2:0] SRC_LFIOSC = 3'd3;
  localparam logic [2:0] SRC_32K    = 3'd7;

  // crystal frequency per xtal code, reserved codes read as zero
  localparam logic [FREQ_W-1:0] XTAL_HZ [32] = '{
    29'd0, 29'd0, 29'd0, 29'd0, 29'd0, 29'd0,
    29'd4000000, 29'd4096000, 29'd4915200, 29'd5000000, 29'd5120000, 29'd6000000,
    29'd6144000, 29'd7372800, 29'd8000000, 29'd8192000, 29'd10000000, 29'd12000000,
    29'd12288000, 29'd13560000, 29'd14318180, 29'd16000000, 29'd16384000,
    29'd18000000, 29'd20000000, 29'd24000000, 29'd25000000,
    29'd0, 29'd0, 29'd0, 29'd0, 29'd0
  };

  // one divider pipeline stage
  typedef struct packed {
    logic [FREQ_W-1:0] quot;     // dividend bits still to go, quotient bits shifted in
    logic [REM_W-1:0]  rem;
    logic [DIV_W-1:0]  divisor;
    logic              setup_valid;
  } sfd_stage_t;

  // crystal lookup with the table length applied
  function automatic logic [FREQ_W-1:0] crystal_hz(logic [4:0] idx);
    logic [FREQ_W-1:0] val;
    val = XTAL_HZ[idx];
    if (int'(idx) >= CRYSTAL_ENTRIES) begin
      val = '0;
    end
    return val;
  endfunction

endpackage

FILE: rtl/system_clock_frequency_decode.sv
// system_clock_frequency_decode: decodes a clock configuration snapshot into hertz
// depends on sfd_pkg for widths, source codes and the crystal table
//
//   channel | ports                                  | direction
//   --------+----------------------------------------+----------
//   in      | in_valid/in_ready, in_rcc_word, in_rcc2_word | input
//   out     | out_valid/out_ready, out_frequency_hz, out_setup_valid | output
//
// one snapshot enters per cycle while out_ready does not stall the pipeline; its result is
// offered after the decode into the first register, then a restoring divider resolving four
// quotient bits a stage
// rst_n clears the stage valid bits only; data registers are not reset
// a stall on out_ready freezes the whole pipeline and drops in_ready

module system_clock_frequency_decode
  import sfd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [31:0]       in_rcc_word,
  input  logic [31:0]       in_rcc2_word,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [FREQ_W-1:0] out_frequency_hz,
  output logic              out_setup_valid
);

  sfd_stage_t stg_r   [NUM_DIV_STG+1];
  sfd_stage_t stg_nxt [NUM_DIV_STG+1];
  logic       vld_r   [NUM_DIV_STG+1];
  logic       vld_nxt [NUM_DIV_STG+1];
  logic       advance;

  // a group of restoring division steps
  function automatic sfd_stage_t div_steps(sfd_stage_t s, int base);
    sfd_stage_t       t;
    logic [REM_W:0]   trial;
    logic             qbit;
    t = s;
    for (int i = 0; i < STEPS_PER_STG; i++) begin
      if (base + i < FREQ_W) begin
        trial  = {t.rem, t.quot[FREQ_W-1]};
        qbit   = (trial >= t.divisor);
        t.quot = {t.quot[FREQ_W-2:0], qbit};
        if (qbit) begin
          t.rem = REM_W'(trial - t.divisor);
        end else begin
          t.rem = trial[REM_W-1:0];
        end
      end
    end
    return t;
  endfunction

  // pipeline moves whenever the output slot is free or being taken
  assign advance  = !vld_r[NUM_DIV_STG] || out_ready;
  assign in_ready = advance;

  // field decode into dividend and divisor
  always_comb begin
    logic              ovr;
    logic [2:0]        src;
    logic              bypass;
    logic              pll_on;
    logic              use_div;
    logic              ok;
    logic              pll_cap;
    logic [FREQ_W-1:0] src_hz;
    logic [DIV_W-1:0]  sys_div;
    logic [FREQ_W-1:0] num;
    logic [DIV_W-1:0]  dvs;

    ovr     = in_rcc2_word[31];
    use_div = in_rcc_word[22];
    ok      = 1'b1;
    pll_cap = 1'b0;
    src_hz  = '0;
    if (ovr) begin
      src     = in_rcc2_word[6:4];
      bypass  = in_rcc2_word[11];
      pll_on  = !in_rcc2_word[13];
      sys_div = {2'b00, in_rcc2_word[28:23]} + 8'd1;
    end else begin
      src     = {1'b0, in_rcc_word[5:4]};
      bypass  = in_rcc_word[11];
      pll_on  = !in_rcc_word[13];
      sys_div = {4'b0000, in_rcc_word[26:23]} + 8'd1;
    end

    // oscillator source
    unique case (src)
      SRC_MOSC: begin
        // oscillator disable is honoured only under override
        if (ovr && in_rcc_word[0]) begin
          ok = 1'b0;
        end else begin
          src_hz  = crystal_hz(in_rcc_word[10:6]);
          pll_cap = 1'b1;
        end
      end
      SRC_PIOSC: begin
        src_hz  = HZ_PIOSC;
        pll_cap = 1'b1;
      end
      SRC_PIOSC4: src_hz = HZ_PIOSC4;
      SRC_LFIOSC: src_hz = HZ_LFIOSC;
      SRC_32K:    src_hz = HZ_32K;
      default:    ok = 1'b0;
    endcase

    // bypass or pll path
    num = '0;
    dvs = 8'd1;
    if (ok) begin
      if (bypass) begin
        num = src_hz;
        if (use_div) begin
          dvs = sys_div;
        end
      end else if (pll_cap) begin
        if (!pll_on) begin
          ok = 1'b0;
        end else if (ovr && in_rcc2_word[30]) begin
          num = HZ_PLL_400;
          dvs = {1'b0, in_rcc2_word[28:23], in_rcc2_word[22]} + 8'd1;
        end else begin
          num = HZ_PLL_200;
          dvs = sys_div;
        end
      end else begin
        num = src_hz;
      end
    end

    stg_nxt[0].quot        = num;
    stg_nxt[0].rem         = '0;
    stg_nxt[0].divisor     = dvs;
    stg_nxt[0].setup_valid = ok;
    vld_nxt[0]             = in_valid;

    // divider stages
    for (int k = 1; k <= NUM_DIV_STG; k++) begin
      stg_nxt[k] = div_steps(stg_r[k-1], (k - 1) * STEPS_PER_STG);
      vld_nxt[k] = vld_r[k-1];
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= NUM_DIV_STG; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (advance) begin
      for (int k = 0; k <= NUM_DIV_STG; k++) begin
        vld_r[k] <= vld_nxt[k];
      end
    end
  end

  // stage data
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int k = 0; k <= NUM_DIV_STG; k++) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
  end

  assign out_valid        = vld_r[NUM_DIV_STG];
  assign out_frequency_hz = stg_r[NUM_DIV_STG].quot;
  assign out_setup_valid  = stg_r[NUM_DIV_STG].setup_valid;

endmodule

FILE: rtl/sfd_port_check.sv
// sfd_port_check: port-level checks on system_clock_frequency_decode, with its bind
// depends on sfd_pkg for the result width and the highest frequency

module sfd_port_check
  import sfd_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [FREQ_W-1:0] out_frequency_hz,
  input logic              out_setup_valid
);

  // a stalled result transfer keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frequency_hz)
      && $stable(out_setup_valid))
    else $error("result changed while stalled");

  // an invalid setup reports zero hertz
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_setup_valid |-> out_frequency_hz == '0)
    else $error("invalid setup with non-zero frequency");

  // nothing above the 400 MHz pll output
  a_freq_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_frequency_hz <= HZ_PLL_400)
    else $error("frequency above range");

  // input is never held off while the output is being drained
  a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled with output ready");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind system_clock_frequency_decode sfd_port_check u_sfd_port_check (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_frequency_hz (out_frequency_hz),
  .out_setup_valid  (out_setup_valid)
);
